[hw/rtl/u32u16_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u32u16_pkg
// Types and constants shared by the UTF-32/UTF-16 byte decoder core.
// ----------------------------------------------------------------------------
package u32u16_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_ENDIAN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIP_BYTES = 2'd2;

   localparam logic [31:0] MAX_CODE_POINT  = 32'h0010_FFFF;
   localparam logic [31:0] BMP_LIMIT       = 32'h0000_FFFF;
   localparam logic [31:0] SURR_FIRST      = 32'h0000_D800;
   localparam logic [31:0] SURR_LAST       = 32'h0000_DFFF;
   localparam logic [20:0] SUPP_BASE       = 21'h01_0000;
   localparam logic [15:0] REPLACEMENT     = 16'hFFFD;
   localparam logic [5:0]  HIGH_SURR_TAG   = 6'b110110;  // 0xD800 >> 10
   localparam logic [5:0]  LOW_SURR_TAG    = 6'b110111;  // 0xDC00 >> 10

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        unit_valid;
      logic        run_last;
      logic        stream_end;
   } rsp_type;

   // one decoded word (or bare end marker) handed from front to back
   typedef struct packed {
      logic [15:0] unit0;
      logic [9:0]  low_bits;   // low surrogate payload when pair is set
      logic        has_unit;
      logic        pair;
      logic        last;
   } entry_type;

endpackage : u32u16_pkg
`default_nettype wire

[hw/rtl/u32u16_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u32u16_front
// Config registers, byte skip, word gathering and code point classification.
// ----------------------------------------------------------------------------
module u32u16_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_en,
   input  wire logic [u32u16_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [u32u16_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire u32u16_pkg::req_type                req_data,
   input  wire logic                               q_full,
   output logic                                    q_push,
   output u32u16_pkg::entry_type                   q_entry
);
   import u32u16_pkg::*;

   logic        wide_mode_ff, big_endian_ff;
   logic [2:0]  skip_bytes_ff;
   logic [23:0] gathered_ff, gathered_in;
   logic [1:0]  pos_ff, pos_in;
   logic [2:0]  skipped_ff, skipped_in;

   logic        accept;
   logic        skipping;
   logic        complete;
   logic [7:0]  b0, b1, b2, d;
   logic [31:0] cp;
   logic [20:0] supp_offset;
   entry_type   ent;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign d        = req_data.data_byte;
   assign b0       = gathered_ff[7:0];
   assign b1       = gathered_ff[15:8];
   assign b2       = gathered_ff[23:16];
   assign skipping = skipped_ff < skip_bytes_ff;
   assign complete = !skipping && (pos_ff >= (wide_mode_ff ? 2'd3 : 2'd1));
   assign cp       = big_endian_ff ? {b0, b1, b2, d} : {d, b2, b1, b0};
   assign supp_offset = cp[20:0] - SUPP_BASE;

   always_comb begin
      ent          = '0;
      ent.last     = req_data.last_byte;
      ent.has_unit = complete;
      if (complete) begin
         if (!wide_mode_ff) begin
            ent.unit0 = big_endian_ff ? {b0, d} : {d, b0};
         end else if (cp > MAX_CODE_POINT) begin
            ent.unit0 = REPLACEMENT;
         end else if (cp <= BMP_LIMIT) begin
            if (cp >= SURR_FIRST && cp <= SURR_LAST) begin
               ent.unit0 = REPLACEMENT;
            end else begin
               ent.unit0 = cp[15:0];
            end
         end else begin
            ent.pair     = 1'b1;
            ent.unit0    = {HIGH_SURR_TAG, supp_offset[19:10]};
            ent.low_bits = supp_offset[9:0];
         end
      end
   end

   assign q_entry = ent;
   assign q_push  = accept && (ent.has_unit || ent.last);

   always_comb begin
      gathered_in = gathered_ff;
      pos_in      = pos_ff;
      skipped_in  = skipped_ff;
      if (accept) begin
         if (skipping) begin
            skipped_in = skipped_ff + 3'd1;
         end else if (complete) begin
            gathered_in = '0;
            pos_in      = '0;
         end else begin
            unique case (pos_ff)
               2'd0:    gathered_in[7:0]   = d;
               2'd1:    gathered_in[15:8]  = d;
               default: gathered_in[23:16] = d;
            endcase
            pos_in = pos_ff + 2'd1;
         end
         if (req_data.last_byte) begin
            gathered_in = '0;
            pos_in      = '0;
            skipped_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_mode_ff  <= 1'b0;
         big_endian_ff <= 1'b0;
         skip_bytes_ff <= '0;
         gathered_ff   <= '0;
         pos_ff        <= '0;
         skipped_ff    <= '0;
      end else begin
         gathered_ff <= gathered_in;
         pos_ff      <= pos_in;
         skipped_ff  <= skipped_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_WIDE_MODE:  wide_mode_ff  <= csr_wdata[0];
               CSR_BIG_ENDIAN: big_endian_ff <= csr_wdata[0];
               CSR_SKIP_BYTES: skip_bytes_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_byte |=> pos_ff == 2'd0 && skipped_ff == 3'd0)
      else $error("stream state not cleared after last beat");

   a_gather_bound: assert property (@(posedge clock) disable iff (reset)
      accept && !skipping && !complete |=> pos_ff != 2'd0 || $past(req_data.last_byte))
      else $error("gather did not advance position");

endmodule : u32u16_front
`default_nettype wire

[hw/rtl/u32u16_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u32u16_queue
// Small register queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
module u32u16_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire u32u16_pkg::entry_type push_entry,
   output logic                       full,
   input  wire logic                  pop,
   output u32u16_pkg::entry_type      head,
   output logic                       empty
);
   import u32u16_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type         slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full  = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule : u32u16_queue
`default_nettype wire

[hw/rtl/u32u16_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u32u16_back
// Expands queued entries into one or two result beats on the output side.
// ----------------------------------------------------------------------------
module u32u16_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   input  wire u32u16_pkg::entry_type q_head,
   output logic                       q_pop,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output u32u16_pkg::rsp_type        rsp_data
);
   import u32u16_pkg::*;

   entry_type ent_ff;
   logic      valid_ff, valid_in;
   logic      second_ff, second_in;
   logic      take;
   logic      advance;

   assign rsp_empty = !valid_ff;
   assign advance   = rsp_pop && valid_ff && ent_ff.pair && !second_ff;
   assign take      = !valid_ff || (rsp_pop && !advance);
   assign q_pop     = take && !q_empty;

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      if (advance) begin
         second_in = 1'b1;
      end else if (take) begin
         valid_in  = !q_empty;
         second_in = 1'b0;
      end
   end

   always_comb begin
      if (second_ff) begin
         rsp_data.code_unit  = {LOW_SURR_TAG, ent_ff.low_bits};
         rsp_data.unit_valid = 1'b1;
         rsp_data.run_last   = 1'b1;
         rsp_data.stream_end = ent_ff.last;
      end else begin
         rsp_data.code_unit  = ent_ff.unit0;
         rsp_data.unit_valid = ent_ff.has_unit;
         rsp_data.run_last   = !ent_ff.pair;
         rsp_data.stream_end = ent_ff.last && !ent_ff.pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ent_ff <= q_head;
      end
   end

   a_second_of_pair: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> valid_ff && ent_ff.pair)
      else $error("second unit shown without a surrogate pair");

endmodule : u32u16_back
`default_nettype wire

[hw/rtl/utf32_utf16_byte_decoder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf32_utf16_byte_decoder_core
// Byte stream to UTF-16 code unit decoder for UTF-16 and UTF-32 input.
// ----------------------------------------------------------------------------
//  port group | dir | handshake          | beat
//  req_*      | in  | req_push / req_full | one byte + last flag
//  rsp_*      | out | rsp_pop / rsp_empty | one code unit or end marker
//  csr_*      | in  | csr_write_en        | one register write
//
//  One byte is taken per cycle while req_full is low; the front decodes it in that same cycle.
//  A byte yields zero, one or two beats; the back drains one beat per cycle while rsp_pop is high.
//  A word of two surrogate beats holds the back until both beats are popped.
//  The queue (QUEUE_DEPTH entries) absorbs output stalls; req_full rises when it fills.
//  Synchronous active-high reset clears registers and stream state.
// ----------------------------------------------------------------------------
module utf32_utf16_byte_decoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_en,
   input  wire logic [u32u16_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [u32u16_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire u32u16_pkg::req_type                req_data,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output u32u16_pkg::rsp_type                     rsp_data
);
   import u32u16_pkg::*;

   logic      q_push, q_full, q_pop, q_empty;
   entry_type q_entry, q_head;

   u32u16_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (q_entry)
   );

   u32u16_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   u32u16_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule : utf32_utf16_byte_decoder_core
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-32/UTF-16 byte decoder core. A directed
// table covers field extremes, replacement, surrogate pairs, skip and end
// markers, and a mode switch inside a word. Random phases then send mostly
// well-formed streams under several register settings and idle patterns. Every
// accepted result beat is checked against table notes or an in-bench decoder.
// ----------------------------------------------------------------------------
module tb_top;
   import u32u16_pkg::*;

   localparam int HOLD_CYCLES    = 64;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_BYTES    = 50;
   localparam int HOLD_PHASE     = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;
   typedef enum logic {ROW_CSR, ROW_BYTE} row_kind_type;

   typedef struct packed {
      logic        typed;
      logic [1:0]  count;
      rsp_type     unit0;
      rsp_type     unit1;
   } beat_note_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
      req_type                beat;
      beat_note_type          note;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_push;
   logic                   req_full;
   req_type                req_data;
   logic                   rsp_empty;
   logic                   rsp_pop;
   rsp_type                rsp_data;

   // decoder copy: registers and stream state
   logic        mode_wide;
   logic        order_big;
   logic [2:0]  skip_len;
   logic [23:0] word_bytes;
   logic [1:0]  word_count;
   logic [2:0]  skip_count;

   rsp_type       expected_units[$];
   beat_note_type beat_notes[$];
   stim_row_type  directed_rows[$];

   int errors;
   int beats_in;
   int beats_out;
   int csr_writes;
   int idle_cycles;
   int send_pct;
   int recv_pct;
   bit hold_request;

   beat_note_type note_now;
   int            n_now;
   rsp_type       r0_now;
   rsp_type       r1_now;
   rsp_type       exp_now;
   logic          moved;

   utf32_utf16_byte_decoder_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic decode_byte(input req_type b, output int n, output rsp_type r0,
                              output rsp_type r1);
      logic [31:0] cp;
      logic [15:0] u0;
      logic [15:0] u1;
      logic [7:0]  d;
      logic [7:0]  b0;
      logic [7:0]  b1;
      logic [7:0]  b2;
      d  = b.data_byte;
      n  = 0;
      u0 = '0;
      u1 = '0;
      r0 = '0;
      r1 = '0;
      if (skip_count < skip_len) begin
         skip_count = skip_count + 3'd1;
      end else if (word_count >= (mode_wide ? 2'd3 : 2'd1)) begin
         b0 = word_bytes[7:0];
         b1 = word_bytes[15:8];
         b2 = word_bytes[23:16];
         if (mode_wide) begin
            cp = order_big ? {b0, b1, b2, d} : {d, b2, b1, b0};
            if (cp > MAX_CODE_POINT) cp = {16'h0000, REPLACEMENT};
            if (cp <= BMP_LIMIT) begin
               if (cp >= SURR_FIRST && cp <= SURR_LAST) u0 = REPLACEMENT;
               else u0 = cp[15:0];
               n = 1;
            end else begin
               cp = cp - {11'h000, SUPP_BASE};
               u0 = {HIGH_SURR_TAG, cp[19:10]};
               u1 = {LOW_SURR_TAG, cp[9:0]};
               n  = 2;
            end
         end else begin
            u0 = order_big ? {b0, d} : {d, b0};
            n  = 1;
         end
         word_bytes = '0;
         word_count = '0;
      end else begin
         word_bytes[8*word_count +: 8] = d;
         word_count = word_count + 2'd1;
      end
      if (n == 1) r0 = {u0, 1'b1, 1'b1, b.last_byte};
      if (n == 2) begin
         r0 = {u0, 3'b100};
         r1 = {u1, 1'b1, 1'b1, b.last_byte};
      end
      if (b.last_byte) begin
         if (n == 0) begin
            r0 = {16'h0000, 3'b011};
            n  = 1;
         end
         word_bytes = '0;
         word_count = '0;
         skip_count = '0;
      end
   endtask

   task automatic report_field(input string name, input int want, input int got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
   endtask

   // accept monitor: predict input beats first, then check result beats
   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (req_push && !req_full) begin
            moved = 1'b1;
            beats_in++;
            note_now = (beat_notes.size() != 0) ? beat_notes.pop_front() : '0;
            decode_byte(req_data, n_now, r0_now, r1_now);
            if (note_now.typed) begin
               n_now  = note_now.count;
               r0_now = note_now.unit0;
               r1_now = note_now.unit1;
            end
            if (n_now > 0) expected_units.insert(expected_units.size(), r0_now);
            if (n_now > 1) expected_units.insert(expected_units.size(), r1_now);
         end
         if (rsp_pop && !rsp_empty) begin
            moved = 1'b1;
            beats_out++;
            if (expected_units.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_data);
               errors++;
            end else begin
               exp_now = expected_units.pop_front();
               if (rsp_data.code_unit !== exp_now.code_unit)
                  report_field("code_unit", exp_now.code_unit, rsp_data.code_unit);
               if (rsp_data.unit_valid !== exp_now.unit_valid)
                  report_field("unit_valid", exp_now.unit_valid, rsp_data.unit_valid);
               if (rsp_data.run_last !== exp_now.run_last)
                  report_field("run_last", exp_now.run_last, rsp_data.run_last);
               if (rsp_data.stream_end !== exp_now.stream_end)
                  report_field("stream_end", exp_now.stream_end, rsp_data.stream_end);
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // result side
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_pct);
         end
      end
   end

   task automatic push_beat(input req_type beat, input beat_note_type note);
      while ($urandom_range(99) < send_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      beat_notes.insert(beat_notes.size(), note);
      req_push <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_units.size() != 0 || hold_request) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= value;
      @(posedge clock);
      case (index)
         CSR_WIDE_MODE:  mode_wide = value[0];
         CSR_BIG_ENDIAN: order_big = value[0];
         CSR_SKIP_BYTES: skip_len  = value;
         default: ;
      endcase
      csr_writes++;
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_csr(input logic [CSR_INDEX_W-1:0] index,
                          input logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.index = index;
      row.value = value;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_checked(input logic [7:0] d, input logic last, input int n,
                              input rsp_type u0, input rsp_type u1);
      stim_row_type row;
      row            = '0;
      row.kind       = ROW_BYTE;
      row.beat       = {d, last};
      row.note.typed = (n >= 0);
      row.note.count = (n >= 0) ? n[1:0] : 2'd0;
      row.note.unit0 = u0;
      row.note.unit1 = u1;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic add_beat(input logic [7:0] d, input logic last);
      add_checked(d, last, -1, '0, '0);
   endtask

   function automatic req_type random_byte();
      req_type b;
      b.data_byte = 8'($urandom_range(255));
      b.last_byte = 1'b0;
      return b;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0, 1, 2: return $urandom_range(16'hFFFF);
         3:       return SURR_FIRST + $urandom_range(16'h07FF);
         4, 5, 6: return {11'h000, SUPP_BASE} + $urandom_range(20'hFFFFF);
         7:       return $urandom;
         default: begin
            case ($urandom_range(6))
               0:       return 32'h0000_0000;
               1:       return BMP_LIMIT;
               2:       return SURR_LAST;
               3:       return {11'h000, SUPP_BASE};
               4:       return MAX_CODE_POINT;
               5:       return MAX_CODE_POINT + 32'd1;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   task automatic send_stream(output int sent);
      req_type       bytes_q[$];
      req_type       b;
      beat_note_type plain;
      logic [31:0]   value;
      int            wsize;
      int            i;
      int            k;
      plain = '0;
      wsize = mode_wide ? 4 : 2;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 9)) bytes_q.insert(bytes_q.size(), random_byte());
      end else begin
         repeat (skip_len) bytes_q.insert(bytes_q.size(), random_byte());
         repeat ($urandom_range(1, 5)) begin
            value = pick_word();
            for (k = 0; k < wsize; k++) begin
               b.last_byte = 1'b0;
               b.data_byte = order_big ? value[8*(wsize-1-k) +: 8] : value[8*k +: 8];
               bytes_q.insert(bytes_q.size(), b);
            end
         end
         if ($urandom_range(99) < 20)
            repeat ($urandom_range(1, wsize - 1))
               bytes_q.insert(bytes_q.size(), random_byte());
      end
      b = bytes_q.pop_back();
      b.last_byte = 1'b1;
      bytes_q.insert(bytes_q.size(), b);
      for (i = 0; i < bytes_q.size(); i++) push_beat(bytes_q[i], plain);
      sent = bytes_q.size();
   endtask

   initial begin
      int            p;
      int            i;
      int            sent;
      int            phase_sent;
      idle_mode_type mode;
      logic          cfg_wide;
      logic          cfg_big;
      logic [2:0]    cfg_skip;

      reset        = 1'b1;
      csr_write_en = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_push     = 1'b0;
      req_data     = '0;
      mode_wide    = 1'b0;
      order_big    = 1'b0;
      skip_len     = '0;
      word_bytes   = '0;
      word_count   = '0;
      skip_count   = '0;
      errors       = 0;
      beats_in     = 0;
      beats_out    = 0;
      csr_writes   = 0;
      idle_cycles  = 0;
      send_pct     = 0;
      recv_pct     = 0;
      hold_request = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 16-bit little endian, no skip
      add_checked(8'h41, 1'b0, 0, '0, '0);
      add_checked(8'h00, 1'b0, 1, {16'h0041, 3'b110}, '0);
      add_checked(8'h00, 1'b0, 0, '0, '0);
      add_checked(8'h00, 1'b1, 1, {16'h0000, 3'b111}, '0);
      add_csr(CSR_BIG_ENDIAN, 3'd1);
      add_checked(8'h12, 1'b0, 0, '0, '0);
      add_checked(8'h34, 1'b1, 1, {16'h1234, 3'b111}, '0);
      // incomplete word at end of stream
      add_checked(8'hAB, 1'b1, 1, {16'h0000, 3'b011}, '0);
      add_csr(CSR_WIDE_MODE, 3'd1);
      add_csr(CSR_BIG_ENDIAN, 3'd0);
      // above the code point range
      add_checked(8'h00, 1'b0, 0, '0, '0);
      add_checked(8'h00, 1'b0, 0, '0, '0);
      add_checked(8'h11, 1'b0, 0, '0, '0);
      add_checked(8'h00, 1'b0, 1, {REPLACEMENT, 3'b110}, '0);
      // top code point, surrogate pair
      add_checked(8'hFF, 1'b0, 0, '0, '0);
      add_checked(8'hFF, 1'b0, 0, '0, '0);
      add_checked(8'h10, 1'b0, 0, '0, '0);
      add_checked(8'h00, 1'b1, 2, {16'hDBFF, 3'b100}, {16'hDFFF, 3'b111});
      add_csr(CSR_BIG_ENDIAN, 3'd1);
      // lone surrogate value
      add_checked(8'h00, 1'b0, 0, '0, '0);
      add_checked(8'h00, 1'b0, 0, '0, '0);
      add_checked(8'hD8, 1'b0, 0, '0, '0);
      add_checked(8'h00, 1'b0, 1, {REPLACEMENT, 3'b110}, '0);
      // switch to 16-bit words with three bytes held
      add_checked(8'h01, 1'b0, 0, '0, '0);
      add_checked(8'h02, 1'b0, 0, '0, '0);
      add_checked(8'h03, 1'b0, 0, '0, '0);
      add_csr(CSR_WIDE_MODE, 3'd0);
      add_beat(8'h04, 1'b1);
      // skipped bytes up to a last byte, spare index ignored
      add_csr(CSR_SKIP_BYTES, 3'd5);
      add_csr(CSR_SPARE, 3'd7);
      add_checked(8'hEF, 1'b0, 0, '0, '0);
      add_checked(8'hBB, 1'b0, 0, '0, '0);
      add_checked(8'hBF, 1'b1, 1, {16'h0000, 3'b011}, '0);

      for (i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            settle();
            write_csr(directed_rows[i].index, directed_rows[i].value);
         end else begin
            push_beat(directed_rows[i].beat, directed_rows[i].note);
         end
      end

      for (p = 0; p < PHASE_COUNT; p++) begin
         settle();
         mode = idle_mode_type'(p % 4);
         case (mode)
            IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
            IDLE_SEND: begin send_pct = 46; recv_pct = 0;  end
            IDLE_RECV: begin send_pct = 0;  recv_pct = 46; end
            IDLE_BOTH: begin send_pct = 8;  recv_pct = 8;  end
         endcase
         case (p)
            0: begin cfg_wide = 1'b0; cfg_big = 1'b0; cfg_skip = 3'd0; end
            1: begin cfg_wide = 1'b1; cfg_big = 1'b1; cfg_skip = 3'd4; end
            2: begin cfg_wide = 1'b1; cfg_big = 1'b0; cfg_skip = 3'd7; end
            3: begin cfg_wide = 1'b0; cfg_big = 1'b1; cfg_skip = 3'd5; end
            default: begin
               cfg_wide = 1'($urandom_range(1));
               cfg_big  = 1'($urandom_range(1));
               cfg_skip = ($urandom_range(9) < 7) ? 3'($urandom_range(4))
                                                  : 3'($urandom_range(7));
            end
         endcase
         write_csr(CSR_WIDE_MODE, {2'b00, cfg_wide});
         write_csr(CSR_BIG_ENDIAN, {2'b00, cfg_big});
         write_csr(CSR_SKIP_BYTES, cfg_skip);
         // long result hold-off while bytes keep coming
         if (p == HOLD_PHASE) hold_request = 1'b1;
         phase_sent = 0;
         while (phase_sent < PHASE_BYTES) begin
            send_stream(sent);
            phase_sent += sent;
         end
      end
      settle();

      $display("summary: %0d byte beats in, %0d result beats checked, %0d register writes",
               beats_in, beats_out, csr_writes);
      $display("summary: both word sizes and byte orders, skip 0..7, stalls and hold-off");
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule : tb_top
